// File: sv/pma_pkg.sv
// Shared types and constants of the path metrics accumulator.
package pma_pkg;

    localparam int HEAD_IN_W  = 16;
    localparam int HEAD_OUT_W = 15;
    localparam int HEAD_PROD_W = 41;

    // round(2^24 * 180 / (64 * pi)): Q3.12 radians to Q9.6 degrees
    localparam logic [23:0] DEG_SCALE = 24'd15019745;
    localparam logic signed [HEAD_PROD_W-1:0] DEG_ROUND = 41'sd8388608;
    localparam logic signed [17:0] HALF_TURN_Q6 = 18'sd11520;
    localparam logic signed [17:0] FULL_TURN_Q6 = 18'sd23040;

    typedef struct packed {
        logic busy;
        logic done;
    } pma_dist_stat_t;

endpackage

// File: sv/pma_dist_unit.sv
// Shared distance unit: squares two differences, then a bit-pair integer square root.
module pma_dist_unit #(
    parameter int POS_BITS = 24
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [POS_BITS-1:0] x0,
    input  logic signed [POS_BITS-1:0] y0,
    input  logic signed [POS_BITS-1:0] x1,
    input  logic signed [POS_BITS-1:0] y1,
    output logic [POS_BITS:0]          root,
    output pma_pkg::pma_dist_stat_t    stat
);
    import pma_pkg::*;

    localparam int MAG_W  = POS_BITS + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int RAD_W  = SQ_W + 2;
    localparam int PAIRS  = RAD_W / 2;
    localparam int ROOT_W = PAIRS;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(PAIRS);

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_SQA  = 3'd1;
    localparam logic [2:0] D_SQB  = 3'd2;
    localparam logic [2:0] D_ADD  = 3'd3;
    localparam logic [2:0] D_ROOT = 3'd4;

    logic [2:0]       state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;
    logic [MAG_W-1:0] mag_a_reg;
    logic [MAG_W-1:0] mag_b_reg;
    logic [SQ_W-1:0]  prod_reg;
    logic [RAD_W-1:0] rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic signed [MAG_W-1:0] dx;
    logic signed [MAG_W-1:0] dy;
    logic [MAG_W-1:0] mag_a;
    logic [MAG_W-1:0] mag_b;
    logic [MAG_W-1:0] mul_op;
    logic [SQ_W-1:0]  prod_w;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;
    logic [REM_W-1:0] rem_next;
    logic [ROOT_W-1:0] root_next;

    assign dx = {x1[POS_BITS-1], x1} - {x0[POS_BITS-1], x0};
    assign dy = {y1[POS_BITS-1], y1} - {y0[POS_BITS-1], y0};
    assign mag_a = dx[MAG_W-1] ? (~dx + MAG_W'(1)) : dx;
    assign mag_b = dy[MAG_W-1] ? (~dy + MAG_W'(1)) : dy;

    assign mul_op = (state_reg == D_SQA) ? mag_a_reg : mag_b_reg;
    assign prod_w = SQ_W'(mul_op) * SQ_W'(mul_op);

    assign rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
    assign trial     = {root_reg, 2'b01};
    assign ge        = (rem_sh >= trial);
    assign rem_next  = ge ? (rem_sh - trial) : rem_sh;
    assign root_next = {root_reg[ROOT_W-2:0], ge};

    assign root      = root_reg[POS_BITS:0];
    assign stat.busy = (state_reg != D_IDLE);
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= D_SQA;
                    end
                end
                D_SQA:
                begin
                    state_reg <= D_SQB;
                end
                D_SQB:
                begin
                    state_reg <= D_ADD;
                end
                D_ADD:
                begin
                    cnt_reg   <= CNT_W'(PAIRS - 1);
                    state_reg <= D_ROOT;
                end
                D_ROOT:
                begin
                    if (cnt_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= D_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    mag_a_reg <= mag_a;
                    mag_b_reg <= mag_b;
                end
            end
            D_SQA:
            begin
                prod_reg <= prod_w;
            end
            D_SQB:
            begin
                rad_reg  <= {2'b00, prod_reg};
                prod_reg <= prod_w;
            end
            D_ADD:
            begin
                rad_reg  <= rad_reg + {2'b00, prod_reg};
                rem_reg  <= '0;
                root_reg <= '0;
            end
            D_ROOT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                rem_reg  <= rem_next;
                root_reg <= root_next;
            end
            default:
            begin
                rem_reg <= rem_reg;
            end
        endcase
    end

endmodule

// File: sv/path_metrics_accumulator_core.sv
// Top level of the path metrics accumulator: pose sequencer, path state and result register.
// One pose word is taken while s_axis_tready is high; the core then stays busy and takes no
// further word until its result has been loaded into the output register. All distances
// come from one shared distance unit: each distance is issued from S_RUN, then takes two
// squarings, one add, POS_BITS + 2 root steps and one hand-back. A pose that starts a path
// needs one distance (origin radius); any other pose needs three (radius, segment,
// displacement). The result word waits in the output register and does not hold back
// acceptance of the next pose.
module path_metrics_accumulator_core #(
    parameter int POS_BITS = 24,
    parameter int SUM_BITS = 40
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // pos_x, pos_y, heading_rad, zero fill
    input  logic [((2*POS_BITS+16+7)/8)*8-1:0] s_axis_tdata,
    // path_begin
    input  logic [0:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // total_length, net_displacement, max_origin_distance, heading_deg, zero fill
    output logic [((SUM_BITS+2*POS_BITS+17+7)/8)*8-1:0] m_axis_tdata
);
    import pma_pkg::*;

    localparam int OUT_F  = SUM_BITS + 2*POS_BITS + 17;
    localparam int OUT_W  = ((OUT_F+7)/8)*8;
    localparam int NET_W  = POS_BITS + 2;
    localparam int SEG_W  = POS_BITS + 1;
    localparam int ACC_W  = ((SUM_BITS > SEG_W) ? SUM_BITS : SEG_W) + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;
    localparam logic [1:0] S_UPD  = 2'd3;

    localparam logic [1:0] JOB_RAD = 2'd0;
    localparam logic [1:0] JOB_SEG = 2'd1;
    localparam logic [1:0] JOB_NET = 2'd2;

    localparam logic [ACC_W-1:0] SUM_MAX = {{(ACC_W-SUM_BITS){1'b0}}, {SUM_BITS{1'b1}}};

    logic [1:0] state_reg;
    logic [1:0] job_reg;
    logic       out_valid_reg;
    logic       have_reg;

    logic signed [POS_BITS-1:0]  x_reg;
    logic signed [POS_BITS-1:0]  y_reg;
    logic signed [HEAD_IN_W-1:0] theta_reg;
    logic                        begin_reg;
    logic signed [POS_BITS-1:0]  start_x_reg;
    logic signed [POS_BITS-1:0]  start_y_reg;
    logic signed [POS_BITS-1:0]  prev_x_reg;
    logic signed [POS_BITS-1:0]  prev_y_reg;
    logic [SUM_BITS-1:0]         len_reg;
    logic [POS_BITS-1:0]         max_r_reg;
    logic [POS_BITS-1:0]         radius_reg;
    logic [SEG_W-1:0]            seg_reg;
    logic [SEG_W-1:0]            net_reg;
    logic signed [HEAD_PROD_W-1:0] head_prod_reg;

    logic [SUM_BITS-1:0]         out_total_reg;
    logic [NET_W-1:0]            out_net_reg;
    logic [POS_BITS-1:0]         out_max_reg;
    logic [HEAD_OUT_W-1:0]       out_head_reg;

    logic                        in_acc;
    logic                        new_path;
    logic                        load_out;
    logic                        dist_start;
    logic signed [POS_BITS-1:0]  op_x0;
    logic signed [POS_BITS-1:0]  op_y0;
    logic [POS_BITS:0]           dist_root;
    pma_dist_stat_t              dist_stat;

    logic [ACC_W-1:0]            len_sum;
    logic [SUM_BITS-1:0]         len_next;
    logic [POS_BITS-1:0]         max_next;
    logic signed [16:0]          deg;
    logic signed [17:0]          wrap_a;
    logic signed [17:0]          wrap_b;
    logic signed [17:0]          head_w;
    logic signed [HEAD_PROD_W-1:0] head_prod;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign new_path      = begin_reg || !have_reg;
    assign load_out      = (state_reg == S_UPD) && (!out_valid_reg || m_axis_tready);
    assign dist_start    = (state_reg == S_RUN);

    always_comb
    begin
        case (job_reg)
            JOB_SEG:
            begin
                op_x0 = prev_x_reg;
                op_y0 = prev_y_reg;
            end
            JOB_NET:
            begin
                op_x0 = start_x_reg;
                op_y0 = start_y_reg;
            end
            default:
            begin
                op_x0 = '0;
                op_y0 = '0;
            end
        endcase
    end

    pma_dist_unit #(
        .POS_BITS (POS_BITS)
    ) u_dist (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start),
        .x0    (op_x0),
        .y0    (op_y0),
        .x1    (x_reg),
        .y1    (y_reg),
        .root  (dist_root),
        .stat  (dist_stat)
    );

    assign len_sum  = ACC_W'(len_reg) + ACC_W'(seg_reg);
    assign len_next = (len_sum > SUM_MAX) ? SUM_MAX[SUM_BITS-1:0] : len_sum[SUM_BITS-1:0];
    assign max_next = (radius_reg > max_r_reg) ? radius_reg : max_r_reg;

    assign head_prod = theta_reg * $signed({1'b0, DEG_SCALE}) + DEG_ROUND;

    // floor shift, then one correction brings it into a single turn
    assign deg    = head_prod_reg[HEAD_PROD_W-1:24];
    assign wrap_a = {deg[16], deg} + HALF_TURN_Q6;
    always_comb
    begin
        if (wrap_a < 18'sd0)
        begin
            wrap_b = wrap_a + FULL_TURN_Q6;
        end
        else if (wrap_a >= FULL_TURN_Q6)
        begin
            wrap_b = wrap_a - FULL_TURN_Q6;
        end
        else
        begin
            wrap_b = wrap_a;
        end
    end
    assign head_w = wrap_b - HALF_TURN_Q6;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= JOB_RAD;
            out_valid_reg <= 1'b0;
            have_reg      <= 1'b0;
            start_x_reg   <= '0;
            start_y_reg   <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            len_reg       <= '0;
            max_r_reg     <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        job_reg   <= JOB_RAD;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN:
                begin
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (dist_stat.done)
                    begin
                        case (job_reg)
                            JOB_RAD:
                            begin
                                if (new_path)
                                begin
                                    state_reg <= S_UPD;
                                end
                                else
                                begin
                                    job_reg   <= JOB_SEG;
                                    state_reg <= S_RUN;
                                end
                            end
                            JOB_SEG:
                            begin
                                job_reg   <= JOB_NET;
                                state_reg <= S_RUN;
                            end
                            default:
                            begin
                                state_reg <= S_UPD;
                            end
                        endcase
                    end
                end
                S_UPD:
                begin
                    if (load_out)
                    begin
                        have_reg      <= 1'b1;
                        prev_x_reg    <= x_reg;
                        prev_y_reg    <= y_reg;
                        if (new_path)
                        begin
                            start_x_reg <= x_reg;
                            start_y_reg <= y_reg;
                            len_reg     <= '0;
                            max_r_reg   <= radius_reg;
                        end
                        else
                        begin
                            len_reg   <= len_next;
                            max_r_reg <= max_next;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            x_reg     <= s_axis_tdata[POS_BITS-1:0];
            y_reg     <= s_axis_tdata[2*POS_BITS-1:POS_BITS];
            theta_reg <= s_axis_tdata[2*POS_BITS+HEAD_IN_W-1:2*POS_BITS];
            begin_reg <= s_axis_tuser[0];
        end
        if (state_reg == S_RUN && job_reg == JOB_RAD)
        begin
            head_prod_reg <= head_prod;
        end
        if (state_reg == S_WAIT && dist_stat.done)
        begin
            case (job_reg)
                JOB_RAD:
                begin
                    radius_reg <= dist_root[POS_BITS-1:0];
                end
                JOB_SEG:
                begin
                    seg_reg <= dist_root;
                end
                default:
                begin
                    net_reg <= dist_root;
                end
            endcase
        end
        if (load_out)
        begin
            out_head_reg <= head_w[HEAD_OUT_W-1:0];
            if (new_path)
            begin
                out_total_reg <= '0;
                out_net_reg   <= '0;
                out_max_reg   <= radius_reg;
            end
            else
            begin
                out_total_reg <= len_next;
                out_net_reg   <= NET_W'(net_reg);
                out_max_reg   <= max_next;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_W-OUT_F){1'b0}}, out_head_reg, out_max_reg,
                            out_net_reg, out_total_reg};

    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !dist_stat.busy)
        else $error("pose taken while distance unit busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        dist_stat.done |-> (state_reg == S_WAIT))
        else $error("distance result with no job waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> (state_reg == S_RUN && job_reg == JOB_RAD))
        else $error("accepted pose did not start with origin radius");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[OUT_F-1:OUT_F-HEAD_OUT_W]) >= -15'sd11520))
        else $error("heading outside half turn");

endmodule
